// ----- src/mlpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types and constants for the multilevel priority ready queue.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  localparam int LEVELS   = 64;
  localparam int THREADS  = 64;
  localparam int LVL_W    = 6;
  localparam int TID_W    = 6;
  localparam int CNT_W    = 7;
  localparam int TOP_W    = 7;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOTQ    = 2'd2;
  localparam logic [1:0] ST_ALREADY = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [TID_W-1:0] tid;
    logic [LVL_W-1:0] lvl;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TID_W-1:0] popped_id;
    logic [TOP_W-1:0] top_level;
    logic [CNT_W-1:0] entry_count;
  } res_t;

endpackage

// ----- src/mlpq_front.sv -----
// ----------------------------------------------------------------------------
// mlpq_front
// Accepts items and holds them in a short command queue.
// ----------------------------------------------------------------------------
module mlpq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mlpq_pkg::cmd_t      in_cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output mlpq_pkg::cmd_t      cmd
);

  mlpq_pkg::cmd_t q_r [mlpq_pkg::CMDQ_DEPTH];
  logic           wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  assign in_ready  = (cnt_r != 2'(mlpq_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid & in_ready;
  assign pop       = cmd_valid & cmd_ready;

  always_comb begin
    wp_nxt  = wp_r + 1'(push);
    rp_nxt  = rp_r + 1'(pop);
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_cmd;
    end
  end

endmodule

// ----- src/mlpq_back.sv -----
// ----------------------------------------------------------------------------
// mlpq_back
// Sequencer that walks the link tables for one command and builds its result.
// ----------------------------------------------------------------------------
module mlpq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  mlpq_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output mlpq_pkg::res_t  res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PHD  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_UNL  = 3'd3;
  localparam logic [2:0] S_PRD  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int LW = mlpq_pkg::LVL_W;
  localparam int TW = mlpq_pkg::TID_W;

  logic [TW-1:0] head_m [mlpq_pkg::LEVELS];
  logic [TW-1:0] tail_m [mlpq_pkg::LEVELS];
  logic [TW-1:0] next_m [mlpq_pkg::THREADS];
  logic [TW-1:0] prev_m [mlpq_pkg::THREADS];
  logic [LW-1:0] tlvl_m [mlpq_pkg::THREADS];

  logic [mlpq_pkg::LEVELS-1:0]  nonempty_r;
  logic [mlpq_pkg::THREADS-1:0] queued_r;
  logic [mlpq_pkg::CNT_W-1:0]   total_r;

  logic [2:0]    state_r;
  logic [1:0]    op_r, status_r;
  logic [TW-1:0] t_r, popped_r;
  logic [LW-1:0] lvl_r, ul_r;
  logic [TW-1:0] hd_r, tl_r, nx_r, pv_r;
  logic          out_v_r;
  mlpq_pkg::res_t res_r;

  logic          top_any;
  logic [LW-1:0] top_idx;
  logic          take;

  always_comb begin
    top_any = 1'b0;
    top_idx = '0;
    for (int i = 0; i < mlpq_pkg::LEVELS; i++) begin
      if (nonempty_r[i]) begin
        top_any = 1'b1;
        top_idx = LW'(i);
      end
    end
  end

  assign cmd_ready = (state_r == S_IDLE) && !out_v_r;
  assign take      = cmd_valid && cmd_ready;
  assign res_valid = out_v_r;
  assign res       = res_r;

  // control, flags and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      nonempty_r <= '0;
      queued_r   <= '0;
      total_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (take) begin
            op_r     <= cmd.op;
            t_r      <= cmd.tid;
            lvl_r    <= cmd.lvl;
            popped_r <= '0;
            if (cmd.op == mlpq_pkg::OP_POP) begin
              if (!top_any) begin
                status_r <= mlpq_pkg::ST_EMPTY;
                state_r  <= S_OUT;
              end else begin
                status_r <= mlpq_pkg::ST_OK;
                state_r  <= S_PHD;
              end
            end else if (cmd.op == mlpq_pkg::OP_INSERT) begin
              if (queued_r[cmd.tid]) begin
                status_r <= mlpq_pkg::ST_ALREADY;
                state_r  <= S_OUT;
              end else begin
                status_r <= mlpq_pkg::ST_OK;
                state_r  <= S_PRD;
              end
            end else begin
              if (!queued_r[cmd.tid]) begin
                status_r <= mlpq_pkg::ST_NOTQ;
                state_r  <= S_OUT;
              end else begin
                status_r <= mlpq_pkg::ST_OK;
                state_r  <= S_RD;
              end
            end
          end
        end
        S_PHD: begin
          t_r      <= hd_r;
          popped_r <= hd_r;
          state_r  <= S_UNL;
        end
        S_RD: begin
          state_r <= S_UNL;
        end
        S_UNL: begin
          if (hd_r == t_r && tl_r == t_r) begin
            nonempty_r[ul_r] <= 1'b0;
          end
          queued_r[t_r] <= 1'b0;
          total_r       <= total_r - 1'b1;
          state_r       <= (op_r == mlpq_pkg::OP_UPDATE) ? S_PRD : S_OUT;
        end
        S_PRD: begin
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!nonempty_r[lvl_r]) begin
            nonempty_r[lvl_r] <= 1'b1;
          end
          queued_r[t_r] <= 1'b1;
          total_r       <= total_r + 1'b1;
          state_r       <= S_OUT;
        end
        S_OUT: begin
          res_r.status      <= status_r;
          res_r.popped_id   <= popped_r;
          res_r.top_level   <= top_any ? {1'b0, top_idx} : {mlpq_pkg::TOP_W{1'b1}};
          res_r.entry_count <= total_r;
          state_r           <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // link tables, read into registers and written by the sequencer steps
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (take) begin
          if (cmd.op == mlpq_pkg::OP_POP) begin
            hd_r <= head_m[top_idx];
            ul_r <= top_idx;
          end else begin
            ul_r <= tlvl_m[cmd.tid];
            nx_r <= next_m[cmd.tid];
            pv_r <= prev_m[cmd.tid];
          end
        end
      end
      S_PHD: begin
        tl_r <= tail_m[ul_r];
        nx_r <= next_m[hd_r];
        pv_r <= prev_m[hd_r];
      end
      S_RD: begin
        hd_r <= head_m[ul_r];
        tl_r <= tail_m[ul_r];
      end
      S_UNL: begin
        if (hd_r == t_r && tl_r == t_r) begin
          // level becomes empty, nothing to relink
        end else if (hd_r == t_r) begin
          head_m[ul_r] <= nx_r;
        end else if (tl_r == t_r) begin
          tail_m[ul_r] <= pv_r;
          next_m[pv_r] <= pv_r;
        end else begin
          next_m[pv_r] <= nx_r;
          prev_m[nx_r] <= pv_r;
        end
      end
      S_PRD: begin
        tl_r        <= tail_m[lvl_r];
        next_m[t_r] <= t_r;
      end
      S_PUSH: begin
        if (nonempty_r[lvl_r]) begin
          next_m[tl_r] <= t_r;
          prev_m[t_r]  <= tl_r;
        end else begin
          head_m[lvl_r] <= t_r;
          prev_m[t_r]   <= t_r;
        end
        tail_m[lvl_r] <= t_r;
        tlvl_m[t_r]   <= lvl_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (state_r == S_OUT) begin
      out_v_r <= 1'b1;
    end else if (out_v_r && res_ready) begin
      out_v_r <= 1'b0;
    end
  end

endmodule

// ----- src/multilevel_priority_ready_queue_top.sv -----
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue_top
// Ready queue with one linked FIFO of thread ids per priority level.
//
//  channel | dir | tdata fields (low bit up)
//  in_     | in  | op[1:0], thread_id[7:2], priority_req[13:8]
//  out_    | out | status[1:0], popped_id[7:2], top_level[14:8], entry_count[21:15]
//
// a taken command runs registered table steps, then S_OUT: pop S_PHD, S_UNL; remove
// S_RD, S_UNL; insert S_PRD, S_PUSH; update S_RD, S_UNL, S_PRD, S_PUSH; errors none.
// the two-entry command queue registers items and accepts more while it has room.
// a result register holds each item until taken; the sequencer waits for it.
// reset is synchronous and clears the queued and non-empty flags and the count.
// ----------------------------------------------------------------------------
module multilevel_priority_ready_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op, thread_id, priority_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status, popped_id, top_level, entry_count
);

  mlpq_pkg::cmd_t in_cmd, cmd;
  mlpq_pkg::res_t res;
  logic           cmd_valid, cmd_ready;

  assign in_cmd.op  = in_tdata[1:0];
  assign in_cmd.tid = in_tdata[7:2];
  assign in_cmd.lvl = in_tdata[13:8];

  assign out_tdata = {2'b00, res.entry_count, res.top_level, res.popped_id, res.status};

  mlpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mlpq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

endmodule
